// File: design/ptt_pkg.sv
// shared types and constants of the periodic task timer table
package ptt_pkg;
  localparam int unsigned TaskSlotsDef = 16;
  localparam int unsigned TimeW = 32;

  typedef enum logic [1:0] {
    ACT_ADD = 2'd0, ACT_REMOVE = 2'd1, ACT_EDIT = 2'd2, ACT_TICK = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    KIND_ACK = 2'd0, KIND_RESCHED = 2'd1, KIND_REMOVED = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_FULL = 2'd1, ST_NOTASK = 2'd2
  } status_e;

  // one slot packed: ident, job, period, end, start
  localparam int unsigned SlotW = 16 + 8 + 3 * TimeW;
  typedef struct packed {
    logic [15:0]      ident;
    logic [7:0]       job;
    logic [TimeW-1:0] period;
    logic [TimeW-1:0] end_t;
    logic [TimeW-1:0] start;
  } slot_t;
endpackage

// File: design/periodic_task_timer_table.sv
// top level of the periodic task timer table
// Usage: commands come in on the s_axis channel, one transfer each; tuser
// carries the action (add, remove by position, edit by identifier, tick).
// Add, remove and edit answer with one acknowledgement on m_axis; a tick
// answers with one transfer per fired task, in list order, and none when
// nothing is due. tlast marks the final result of a command.
// The table lives in one slot ram with a registered read; every task is
// touched through its one read port and one write port, and next start
// times are reckoned in 33 bits. A remove compacts the table by moving
// each following slot down; an edit searches slot by slot for the ident;
// a tick reads every slot, runs a catch-up division for a task that fell
// more than one period behind and compacts the table for each removal.
// A fire result is held until the scan knows whether another one
// follows, so that tlast can mark the final one. The block takes one
// command at a time; s_axis_tready is low until its last result has
// been transferred. The result register holds while m_axis_tready is
// low and the sequencer waits. Reset empties the table (task count
// zero); slot contents are don't-care until written.
module periodic_task_timer_table #(
  parameter int unsigned TaskSlots = ptt_pkg::TaskSlotsDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // position[3:0], task_ident[19:4], start_time[51:20], end_time[83:52],
  // period[115:84], job_number[123:116], current_time[155:124]
  input  logic [159:0] s_axis_tdata,
  // action
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status[1:0], fired_job[9:2], fired_ident[25:10], next_start[57:26]
  output logic [63:0]  m_axis_tdata,
  // kind
  output logic [1:0]   m_axis_tuser,
  output logic         m_axis_tlast
);
  import ptt_pkg::*;
  localparam int unsigned IdxW = $clog2(TaskSlots);
  localparam int unsigned CntW = $clog2(TaskSlots + 1);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_READ   = 10'b0000000010,
    S_EVAL   = 10'b0000000100,
    S_DIV    = 10'b0000001000,
    S_WAIT   = 10'b0000010000,
    S_ADD    = 10'b0000100000,
    S_SHIFT  = 10'b0001000000,
    S_SHWR   = 10'b0010000000,
    S_OUT    = 10'b0100000000,
    S_NEXT   = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  // input item fields
  logic [3:0]       in_pos;
  slot_t            in_slot;
  logic [TimeW-1:0] in_now;
  assign in_pos         = s_axis_tdata[3:0];
  assign in_slot.ident  = s_axis_tdata[19:4];
  assign in_slot.start  = s_axis_tdata[51:20];
  assign in_slot.end_t  = s_axis_tdata[83:52];
  assign in_slot.period = s_axis_tdata[115:84];
  assign in_slot.job    = s_axis_tdata[123:116];
  assign in_now         = s_axis_tdata[155:124];

  // registers
  logic [CntW-1:0]  count_q, count_d, idx_q, idx_d, sh_q, sh_d;
  action_e          act_q, act_d;
  slot_t            cmd_q, cmd_d;
  logic [TimeW-1:0] now_q, now_d;
  slot_t            cur_q, cur_d;
  logic [TimeW:0]   nxt_q, nxt_d;
  logic             rem_q, rem_d;
  logic             fired_q, fired_d;
  logic             ovalid_q, ovalid_d, olast_q, olast_d;
  kind_e            okind_q, okind_d;
  status_e          ostat_q, ostat_d;
  logic [7:0]       ojob_q, ojob_d;
  logic [15:0]      oid_q, oid_d;
  logic [TimeW-1:0] onext_q, onext_d;
  // fire result held until the next one or the end of the scan
  kind_e            hkind_q, hkind_d;
  logic [7:0]       hjob_q, hjob_d;
  logic [15:0]      hid_q, hid_d;
  logic [TimeW-1:0] hnext_q, hnext_d;

  // slot ram
  logic             we;
  logic [IdxW-1:0]  waddr, raddr;
  slot_t            wdata, rdata;
  ptt_ram #(.Width(SlotW), .Depth(TaskSlots)) u_ram (
    .clk_i(clk_i), .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  // catch-up divider: remainder of (now - next) by the period
  logic             div_start, div_done;
  logic [TimeW-1:0] div_rem, div_dividend;
  assign div_dividend = now_q - nxt_q[TimeW-1:0];
  ptt_divider u_div (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(div_start),
    .dividend_i(div_dividend), .divisor_i(cur_q.period),
    .done_o(div_done), .rem_o(div_rem)
  );

  // first start past now: now - remainder + period
  logic [TimeW:0] catch_sum;
  assign catch_sum = {1'b0, now_q} - {1'b0, div_rem} + {1'b0, cur_q.period};

  logic out_free;
  assign out_free = !ovalid_q || m_axis_tready;

  // sequencer
  always_comb begin
    state_d = state_q; count_d = count_q; idx_d = idx_q; sh_d = sh_q;
    act_d = act_q; cmd_d = cmd_q; now_d = now_q; cur_d = cur_q;
    nxt_d = nxt_q; rem_d = rem_q;
    fired_d = fired_q;
    ovalid_d = ovalid_q && !m_axis_tready;
    olast_d = olast_q; okind_d = okind_q; ostat_d = ostat_q;
    ojob_d = ojob_q; oid_d = oid_q; onext_d = onext_q;
    hkind_d = hkind_q; hjob_d = hjob_q; hid_d = hid_q; hnext_d = hnext_q;
    we = 1'b0; waddr = idx_q[IdxW-1:0]; wdata = cur_q;
    raddr = idx_q[IdxW-1:0]; div_start = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid && !ovalid_q) begin
          act_d = action_e'(s_axis_tuser);
          cmd_d = in_slot; now_d = in_now; fired_d = 1'b0;
          unique case (action_e'(s_axis_tuser))
            ACT_ADD: begin
              ostat_d = ST_OK;
              if (count_q == CntW'(TaskSlots)) ostat_d = ST_FULL;
              else begin
                we = 1'b1; waddr = count_q[IdxW-1:0]; wdata = in_slot;
                count_d = count_q + 1'b1;
              end
              state_d = S_OUT;
            end
            ACT_REMOVE: begin
              if (CntW'(in_pos) < count_q && 32'(in_pos) < TaskSlots) begin
                ostat_d = ST_OK;
                sh_d = CntW'(in_pos);
                state_d = S_SHIFT;
              end else begin
                ostat_d = ST_NOTASK;
                state_d = S_OUT;
              end
            end
            default: begin
              idx_d = '0;
              state_d = S_NEXT;
            end
          endcase
        end
      end
      S_NEXT: begin
        // pick the next slot or finish
        if (idx_q >= count_q) begin
          if (act_q == ACT_EDIT) begin
            ostat_d = ST_NOTASK;
            state_d = S_OUT;
          end else if (fired_q) begin
            // release the held fire result as the final one
            if (out_free) begin
              ovalid_d = 1'b1; olast_d = 1'b1; ostat_d = ST_OK;
              okind_d = hkind_q; ojob_d = hjob_q; oid_d = hid_q; onext_d = hnext_q;
              fired_d = 1'b0;
              state_d = S_IDLE;
            end
          end else state_d = S_IDLE;
        end else state_d = S_READ;
      end
      S_READ: state_d = S_EVAL;
      S_EVAL: begin
        cur_d = rdata;
        if (act_q == ACT_EDIT) begin
          if (rdata.ident == cmd_q.ident) begin
            we = 1'b1; wdata = cmd_q;
            ostat_d = ST_OK;
            state_d = S_OUT;
          end else begin
            idx_d = idx_q + 1'b1;
            state_d = S_NEXT;
          end
        end else if (rdata.start > now_q) begin
          idx_d = idx_q + 1'b1;
          state_d = S_NEXT;
        end else if (rdata.period == '0) begin
          rem_d = 1'b1;
          state_d = S_ADD;
          nxt_d = '0;
        end else begin
          nxt_d = {1'b0, rdata.start} + {1'b0, rdata.period};
          rem_d = 1'b0;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        // end check, then catch-up when still not past now
        if (cur_q.end_t != '0 && nxt_q > {1'b0, cur_q.end_t}) begin
          rem_d = 1'b1; state_d = S_ADD;
        end else if (nxt_q > {1'b0, now_q}) begin
          rem_d = nxt_q[TimeW];
          state_d = S_ADD;
        end else begin
          div_start = 1'b1;
          state_d = S_WAIT;
        end
      end
      S_WAIT: begin
        // wait for the remainder, then jump past now in one step
        if (div_done) begin
          nxt_d = catch_sum;
          rem_d = catch_sum[TimeW];
          state_d = S_ADD;
        end
      end
      S_ADD: begin
        // pass on the held fire result, hold this one
        if (out_free || !fired_q) begin
          if (fired_q) begin
            ovalid_d = 1'b1; olast_d = 1'b0; ostat_d = ST_OK;
            okind_d = hkind_q; ojob_d = hjob_q; oid_d = hid_q; onext_d = hnext_q;
          end
          fired_d = 1'b1;
          hjob_d = cur_q.job; hid_d = cur_q.ident;
          if (rem_q) begin
            hkind_d = KIND_REMOVED; hnext_d = '0;
            sh_d = idx_q; state_d = S_SHIFT;
          end else begin
            hkind_d = KIND_RESCHED; hnext_d = nxt_q[TimeW-1:0];
            we = 1'b1; wdata = cur_q; wdata.start = nxt_q[TimeW-1:0];
            idx_d = idx_q + 1'b1; state_d = S_NEXT;
          end
        end
      end
      S_SHIFT: begin
        // compaction: read slot sh+1
        if (sh_q + 1'b1 >= count_q) begin
          count_d = count_q - 1'b1;
          state_d = (act_q == ACT_TICK) ? S_NEXT : S_OUT;
        end else begin
          raddr = IdxW'(sh_q + 1'b1);
          state_d = S_SHWR;
        end
      end
      S_SHWR: begin
        we = 1'b1; waddr = sh_q[IdxW-1:0]; wdata = rdata;
        sh_d = sh_q + 1'b1;
        state_d = S_SHIFT;
      end
      S_OUT: begin
        if (out_free) begin
          ovalid_d = 1'b1; olast_d = 1'b1; okind_d = KIND_ACK;
          ojob_d = '0; oid_d = '0; onext_d = '0;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; count_q <= '0; ovalid_q <= 1'b0;
      act_q <= ACT_ADD; fired_q <= 1'b0;
    end else begin
      state_q <= state_d; count_q <= count_d; ovalid_q <= ovalid_d;
      act_q <= act_d; fired_q <= fired_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d; sh_q <= sh_d; cmd_q <= cmd_d; now_q <= now_d;
    cur_q <= cur_d; nxt_q <= nxt_d;
    rem_q <= rem_d; olast_q <= olast_d; okind_q <= okind_d;
    ostat_q <= ostat_d; ojob_q <= ojob_d; oid_q <= oid_d; onext_q <= onext_d;
    hkind_q <= hkind_d; hjob_q <= hjob_d; hid_q <= hid_d; hnext_q <= hnext_d;
  end

  assign s_axis_tready = (state_q == S_IDLE) && !ovalid_q;
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {6'd0, onext_q, oid_q, ojob_q, ostat_q};
  assign m_axis_tuser  = okind_q;
  assign m_axis_tlast  = olast_q;
endmodule

// File: design/ptt_ram.sv
// generic ram with one write port and one registered read port
module ptt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// File: design/ptt_divider.sv
// restoring divider for the catch-up remainder, one quotient bit per cycle
module ptt_divider (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [ptt_pkg::TimeW-1:0] dividend_i,
  input  logic [ptt_pkg::TimeW-1:0] divisor_i,
  output logic                      done_o,
  output logic [ptt_pkg::TimeW-1:0] rem_o
);
  import ptt_pkg::*;
  localparam int unsigned CntW = $clog2(TimeW + 1);

  logic [TimeW-1:0] rem_q, rem_d, quo_q, quo_d, dvs_q, dvs_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             busy_q, busy_d, done_q, done_d;
  logic [TimeW:0]   trial;

  // one shift-subtract step per cycle
  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, quo_q[TimeW-1]} - {1'b0, dvs_q};
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
      cnt_d  = CntW'(TimeW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[TimeW]) begin
        rem_d = trial[TimeW-1:0];
        quo_d = {quo_q[TimeW-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[TimeW-2:0], quo_q[TimeW-1]};
        quo_d = {quo_q[TimeW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;
endmodule
